@@ hdl/tnbcd_pkg.sv @@
package tnbcd_pkg;

   // String layout
   localparam int TABLE_ENTRIES = 112;
   localparam int DIGIT_SLOTS   = 5;
   localparam int PREFIX_CHARS  = 4;
   localparam int PREFIX_SAT    = PREFIX_CHARS + 1;

   localparam int PLEN_W = $clog2(PREFIX_SAT + 1);
   localparam int DCNT_W = $clog2(DIGIT_SLOTS + 1);
   localparam int PIDX_W = $clog2(PREFIX_CHARS);

   // Queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Character codes
   localparam logic [7:0] CHAR_0 = 8'h30;
   localparam logic [7:0] CHAR_9 = 8'h39;
   localparam logic [7:0] CHAR_A = 8'h41;
   localparam logic [7:0] CHAR_Z = 8'h5A;
   localparam logic [7:0] CHAR_F = 8'h46;
   localparam logic [7:0] CHAR_D = 8'h44;
   localparam logic [7:0] CHAR_J = 8'h4A;

   // Prefix field codes and table offsets
   localparam logic [11:0] NO_MATCH     = 12'hFFF;
   localparam logic [6:0]  ZERO_BASE    = 7'd58;
   localparam logic [6:0]  F_BASE       = 7'd30;
   localparam logic [6:0]  F_BASE_ZERO  = 7'd26;
   localparam logic [6:0]  DJ_IDX       = 7'd56;
   localparam logic [6:0]  DJ_IDX_ZERO  = 7'd52;
   localparam logic [6:0]  FDJ_IDX      = 7'd57;
   localparam logic [6:0]  FDJ_IDX_ZERO = 7'd53;
   localparam logic [6:0]  HUNDRED      = 7'd100;
   localparam logic [3:0]  NIB_NONE     = 4'hF;

   typedef logic [PREFIX_CHARS-1:0][7:0] prefix_chars_type;
   typedef logic [DIGIT_SLOTS-1:0][3:0]  digit_nibbles_type;

   // One classified character on its way to the back end
   typedef struct packed {
      logic [7:0] char_code;
      logic [3:0] nibble;
      logic       is_digit;
      logic       present;
      logic       last;
   } item_type;

   function automatic logic is_upper(input logic [7:0] c);
      return (c >= CHAR_A) && (c <= CHAR_Z);
   endfunction

   // 'F' reads as nibble F, anything else as the low nibble of c - '0'
   function automatic logic [3:0] nibble_of(input logic [7:0] c);
      logic [7:0] diff;
      diff = c - CHAR_0;
      return (c == CHAR_F) ? NIB_NONE : diff[3:0];
   endfunction

   // Table lookup of the prefix, returned as three BCD digits or FFF
   function automatic logic [11:0] prefix_field(input prefix_chars_type chars,
                                                input logic [PLEN_W-1:0] len);
      logic              zero;
      logic [PLEN_W-1:0] l;
      logic [7:0]        a;
      logic [7:0]        b;
      logic [7:0]        d;
      logic [6:0]        idx;
      logic              hit;
      logic              hund;
      logic [6:0]        r;
      logic [14:0]       prod;
      logic [3:0]        tens;
      logic [6:0]        ones;
      zero = (chars[0] == CHAR_0);
      a    = zero ? chars[1] : chars[0];
      b    = zero ? chars[2] : chars[1];
      d    = zero ? chars[3] : chars[2];
      l    = len - PLEN_W'(zero);
      hit  = 1'b1;
      idx  = '0;
      if (len == '0 || len > PLEN_W'(PREFIX_CHARS)) begin
         hit = 1'b0;
      end else if (l == PLEN_W'(1) && is_upper(a)) begin
         idx = 7'(a - CHAR_A);
      end else if (l == PLEN_W'(2) && a == CHAR_F && is_upper(b)) begin
         idx = (zero ? F_BASE_ZERO : F_BASE) + 7'(b - CHAR_A);
      end else if (l == PLEN_W'(2) && a == CHAR_D && b == CHAR_J) begin
         idx = zero ? DJ_IDX_ZERO : DJ_IDX;
      end else if (l == PLEN_W'(3) && a == CHAR_F && b == CHAR_D && d == CHAR_J) begin
         idx = zero ? FDJ_IDX_ZERO : FDJ_IDX;
      end else begin
         hit = 1'b0;
      end
      if (zero) begin
         idx = idx + ZERO_BASE;
      end
      if (!hit || idx >= 7'(TABLE_ENTRIES)) begin
         return NO_MATCH;
      end
      // split into decimal digits; r/10 by reciprocal 205/2048 for r < 100
      hund = (idx >= HUNDRED);
      r    = hund ? (idx - HUNDRED) : idx;
      prod = 15'(r) * 15'd205;
      tens = prod[14:11];
      ones = r - 7'(7'(tens) * 7'd10);
      return {3'b000, hund, tens, ones[3:0]};
   endfunction

endpackage

@@ hdl/tnbcd_front.sv @@
module tnbcd_front import tnbcd_pkg::*; (
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // char_code
   input  logic       req_tuser,   // char_present
   input  logic       req_tlast,
   input  logic       push_ready,
   output logic       push_valid,
   output item_type   push_item
);

   // Accept whenever the queue has room
   assign req_tready = push_ready;

   // Drop empty items that do not close the string
   assign push_valid = req_tvalid && push_ready && (req_tuser || req_tlast);

   // Classify the character
   always_comb begin
      push_item.char_code = req_tdata;
      push_item.nibble    = nibble_of(req_tdata);
      push_item.is_digit  = (req_tdata >= CHAR_0) && (req_tdata <= CHAR_9);
      push_item.present   = req_tuser;
      push_item.last      = req_tlast;
   end

endmodule

@@ hdl/tnbcd_fifo.sv @@
module tnbcd_fifo import tnbcd_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push_valid,
   output logic     push_ready,
   input  item_type push_item,
   output logic     pop_valid,
   input  logic     pop,
   output item_type pop_item
);

   item_type           entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff;
   logic [QPTR_W-1:0]  wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff;
   logic [QPTR_W-1:0]  rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff;
   logic [QCNT_W-1:0]  count_in;
   logic               do_push;
   logic               do_pop;

   assign push_ready = (count_ff < QCNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   // Advance pointers with wrap
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store pushed item
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("queue count beyond depth");

endmodule

@@ hdl/tnbcd_back.sv @@
module tnbcd_back import tnbcd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        pop_valid,
   input  item_type    pop_item,
   output logic        pop,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata    // train_code
);

   prefix_chars_type  prefix_chars_ff;
   prefix_chars_type  prefix_chars_in;
   logic [PLEN_W-1:0] prefix_length_ff;
   logic [PLEN_W-1:0] prefix_length_in;
   logic              in_digit_part_ff;
   logic              in_digit_part_in;
   digit_nibbles_type digit_nibbles_ff;
   digit_nibbles_type digit_nibbles_in;
   logic [DCNT_W-1:0] digit_count_ff;
   logic [DCNT_W-1:0] digit_count_in;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic [31:0]       rsp_data_ff;
   logic [31:0]       rsp_data_in;
   logic              out_free;
   logic              finish;
   logic [31:0]       code;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign pop        = pop_valid && (!pop_item.last || out_free);
   assign finish     = pop && pop_item.last;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Fold the popped character into the string state
   always_comb begin
      prefix_chars_in  = prefix_chars_ff;
      prefix_length_in = prefix_length_ff;
      in_digit_part_in = in_digit_part_ff;
      digit_nibbles_in = digit_nibbles_ff;
      digit_count_in   = digit_count_ff;
      if (pop && pop_item.present) begin
         if (!in_digit_part_ff && (prefix_length_ff == '0 || !pop_item.is_digit)) begin
            if (prefix_length_ff < PLEN_W'(PREFIX_CHARS)) begin
               prefix_chars_in[prefix_length_ff[PIDX_W-1:0]] = pop_item.char_code;
            end
            if (prefix_length_ff < PLEN_W'(PREFIX_SAT)) begin
               prefix_length_in = prefix_length_ff + 1'b1;
            end
         end else begin
            in_digit_part_in = 1'b1;
            if (digit_count_ff < DCNT_W'(DIGIT_SLOTS)) begin
               digit_nibbles_in[digit_count_ff] = pop_item.nibble;
               digit_count_in = digit_count_ff + 1'b1;
            end
         end
      end
   end

   // Build the code from the updated state
   always_comb begin
      if (prefix_length_in == '0) begin
         code = '0;
      end else if (prefix_length_in == PLEN_W'(1) && !is_upper(prefix_chars_in[0])) begin
         // lone non-letter prefix counts as the first digit
         code = {NO_MATCH, nibble_of(prefix_chars_in[0]),
                 digit_nibbles_in[0], digit_nibbles_in[1],
                 digit_nibbles_in[2], digit_nibbles_in[3]};
      end else begin
         code = {prefix_field(prefix_chars_in, prefix_length_in),
                 digit_nibbles_in[0], digit_nibbles_in[1], digit_nibbles_in[2],
                 digit_nibbles_in[3], digit_nibbles_in[4]};
      end
   end

   // Load the output register on the closing item, drop it once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (finish) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = code;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || finish) begin
         prefix_chars_ff  <= '0;
         prefix_length_ff <= '0;
         in_digit_part_ff <= 1'b0;
         digit_nibbles_ff <= {DIGIT_SLOTS{NIB_NONE}};
         digit_count_ff   <= '0;
      end else begin
         prefix_chars_ff  <= prefix_chars_in;
         prefix_length_ff <= prefix_length_in;
         in_digit_part_ff <= in_digit_part_in;
         digit_nibbles_ff <= digit_nibbles_in;
         digit_count_ff   <= digit_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   a_digit_bound: assert property (@(posedge clock) disable iff (reset)
      digit_count_ff <= DCNT_W'(DIGIT_SLOTS))
      else $error("digit count beyond slots");

   a_digits_need_part: assert property (@(posedge clock) disable iff (reset)
      !in_digit_part_ff |-> (digit_count_ff == '0))
      else $error("digits kept before digit part began");

   a_finish_clears: assert property (@(posedge clock) disable iff (reset)
      finish |=> (rsp_valid_ff && prefix_length_ff == '0 && digit_count_ff == '0
                  && !in_digit_part_ff))
      else $error("closing item did not give a result and clear the string");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |-> !finish)
      else $error("pending result overwritten");

endmodule

@@ hdl/train_number_string_to_bcd.sv @@
// Train-number encoder: takes a train number one ASCII character per item and,
// on the item marked tlast, returns one 32-bit code: bits 31..20 hold the three
// BCD digits of the prefix table index (or FFF when the prefix is not in the
// table), bits 19..0 five digit nibbles with the first digit on top, F where a
// digit is missing. An item with tuser low adds no character; if it also
// carries tlast it still closes the string, and a string with no characters
// gives 0. One item is accepted every cycle unless a closing item waits on an
// untaken result: a two-entry queue sits between the input classifier and the
// string assembler, the code is registered in a single output register, and
// input keeps flowing while that result waits, up to the next closing item.
module train_number_string_to_bcd import tnbcd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] char_code
   input  logic        req_tuser,   // [0] char_present
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata    // [31:0] train_code
);

   logic     push_valid;
   logic     push_ready;
   item_type push_item;
   logic     pop_valid;
   logic     pop;
   item_type pop_item;

   tnbcd_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .push_ready (push_ready),
      .push_valid (push_valid),
      .push_item  (push_item)
   );

   tnbcd_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop        (pop),
      .pop_item   (pop_item)
   );

   tnbcd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_item   (pop_item),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
